// File: sv/acm_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath link types for the match counter
// no dependencies

package acm_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 26;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int SYM_W     = $clog2(ALPHABET);
  localparam int ROW_W     = ALPHABET * NODE_W;
  localparam int COUNT_W   = 16;
  localparam int REQ_W     = 2;
  localparam int LETTER_W  = 5;
  localparam int KIND_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STORED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL   = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_PAT_FLAG,
    OP_PAT_RD,
    OP_PAT_UPD,
    OP_END_RD,
    OP_END_INC,
    OP_PAT_DONE,
    OP_B_ROOT_RD,
    OP_B_ROOT_C,
    OP_B_Q_RD,
    OP_B_U_RD,
    OP_B_F_RD,
    OP_B_CHILD,
    OP_B_WB,
    OP_B_DONE,
    OP_S_BAD,
    OP_S_RD,
    OP_S_STEP,
    OP_S_WRD,
    OP_S_WACC,
    OP_S_DONE
  } dp_op_e;

  typedef struct packed {
    logic   take;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             last;
    logic             letter_ok;
    logic             links_built;
    logic             overflow;
    logic             c_last;
    logic             q_nonempty;
    logic             t_zero;
    logic             clr_last;
    logic             out_free;
  } status_t;

endpackage

// File: sv/acm_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for input items and result items
// depends on acm_pkg

interface acm_item_if import acm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [LETTER_W-1:0] letter;
  logic                last;

  modport source (output valid, output req_type, output letter, output last, input ready);
  modport sink   (input valid, input req_type, input letter, input last, output ready);
endinterface

interface acm_result_if import acm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, output result_kind, output match_count, input ready);
  modport sink   (input valid, input result_kind, input match_count, output ready);
endinterface

// File: sv/acm_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the match counter: picks one datapath operation per cycle
// depends on acm_pkg

module acm_ctrl import acm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [4:0] ST_CLEAR     = 5'd0;
  localparam logic [4:0] ST_IDLE      = 5'd1;
  localparam logic [4:0] ST_DISP      = 5'd2;
  localparam logic [4:0] ST_PAT_RD    = 5'd3;
  localparam logic [4:0] ST_PAT_UPD   = 5'd4;
  localparam logic [4:0] ST_PAT_FIN   = 5'd5;
  localparam logic [4:0] ST_END_RD    = 5'd6;
  localparam logic [4:0] ST_END_INC   = 5'd7;
  localparam logic [4:0] ST_PAT_OUT   = 5'd8;
  localparam logic [4:0] ST_B_ROOT_RD = 5'd9;
  localparam logic [4:0] ST_B_ROOT_C  = 5'd10;
  localparam logic [4:0] ST_B_CHECK   = 5'd11;
  localparam logic [4:0] ST_B_Q_RD    = 5'd12;
  localparam logic [4:0] ST_B_U_RD    = 5'd13;
  localparam logic [4:0] ST_B_F_RD    = 5'd14;
  localparam logic [4:0] ST_B_CHILD   = 5'd15;
  localparam logic [4:0] ST_B_WB      = 5'd16;
  localparam logic [4:0] ST_S_DISP    = 5'd17;
  localparam logic [4:0] ST_S_RD      = 5'd18;
  localparam logic [4:0] ST_S_STEP    = 5'd19;
  localparam logic [4:0] ST_S_WALK    = 5'd20;
  localparam logic [4:0] ST_S_WACC    = 5'd21;
  localparam logic [4:0] ST_S_FIN     = 5'd22;
  localparam logic [4:0] ST_S_OUT     = 5'd23;

  logic [4:0] state_q, state_d;
  dp_op_e     op;

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o.take = in_valid_i && in_ready_o;
  assign cmd_o.op   = op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      ST_CLEAR: begin
        op = OP_CLR_STEP;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        unique case (status_i.req)
          REQ_CLEAR: begin
            op      = OP_CLR_INIT;
            state_d = ST_CLEAR;
          end
          REQ_PATTERN: begin
            if (status_i.links_built || !status_i.letter_ok) begin
              op      = OP_PAT_FLAG;
              state_d = ST_PAT_FIN;
            end else if (status_i.overflow) begin
              state_d = ST_PAT_FIN;
            end else begin
              state_d = ST_PAT_RD;
            end
          end
          REQ_TEXT: begin
            state_d = status_i.links_built ? ST_S_DISP : ST_B_ROOT_RD;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_PAT_RD: begin
        op      = OP_PAT_RD;
        state_d = ST_PAT_UPD;
      end
      ST_PAT_UPD: begin
        op      = OP_PAT_UPD;
        state_d = ST_PAT_FIN;
      end
      ST_PAT_FIN: begin
        priority if (!status_i.last) state_d = ST_IDLE;
        else if (status_i.overflow)  state_d = ST_PAT_OUT;
        else                         state_d = ST_END_RD;
      end
      ST_END_RD: begin
        op      = OP_END_RD;
        state_d = ST_END_INC;
      end
      ST_END_INC: begin
        op      = OP_END_INC;
        state_d = ST_PAT_OUT;
      end
      ST_PAT_OUT: begin
        if (status_i.out_free) begin
          op      = OP_PAT_DONE;
          state_d = ST_IDLE;
        end
      end
      ST_B_ROOT_RD: begin
        op      = OP_B_ROOT_RD;
        state_d = ST_B_ROOT_C;
      end
      ST_B_ROOT_C: begin
        op = OP_B_ROOT_C;
        if (status_i.c_last) state_d = ST_B_CHECK;
      end
      ST_B_CHECK: begin
        if (status_i.q_nonempty) begin
          state_d = ST_B_Q_RD;
        end else begin
          op      = OP_B_DONE;
          state_d = ST_S_DISP;
        end
      end
      ST_B_Q_RD: begin
        op      = OP_B_Q_RD;
        state_d = ST_B_U_RD;
      end
      ST_B_U_RD: begin
        op      = OP_B_U_RD;
        state_d = ST_B_F_RD;
      end
      ST_B_F_RD: begin
        op      = OP_B_F_RD;
        state_d = ST_B_CHILD;
      end
      ST_B_CHILD: begin
        op = OP_B_CHILD;
        if (status_i.c_last) state_d = ST_B_WB;
      end
      ST_B_WB: begin
        op      = OP_B_WB;
        state_d = ST_B_CHECK;
      end
      ST_S_DISP: begin
        if (status_i.letter_ok) begin
          state_d = ST_S_RD;
        end else begin
          op      = OP_S_BAD;
          state_d = ST_S_FIN;
        end
      end
      ST_S_RD: begin
        op      = OP_S_RD;
        state_d = ST_S_STEP;
      end
      ST_S_STEP: begin
        op      = OP_S_STEP;
        state_d = ST_S_WALK;
      end
      ST_S_WALK: begin
        if (status_i.t_zero) begin
          state_d = ST_S_FIN;
        end else begin
          op      = OP_S_WRD;
          state_d = ST_S_WACC;
        end
      end
      ST_S_WACC: begin
        op      = OP_S_WACC;
        state_d = ST_S_WALK;
      end
      ST_S_FIN: begin
        state_d = status_i.last ? ST_S_OUT : ST_IDLE;
      end
      ST_S_OUT: begin
        if (status_i.out_free) begin
          op      = OP_S_DONE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/acm_datapath.sv
`timescale 1ns / 1ps
// transition table, fail links, end counts, build queue and cursors of the match counter
// depends on acm_pkg; driven by acm_ctrl

module acm_datapath import acm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [LETTER_W-1:0] letter_i,
  input  logic                last_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KIND_W-1:0]   result_kind_o,
  output logic [COUNT_W-1:0]  match_count_o,
  output status_t             status_o
);

  localparam logic [CNT_W-1:0]   NODES_FULL = CNT_W'(MAX_NODES);
  localparam logic [NODE_W-1:0]  CLR_END    = NODE_W'(MAX_NODES - 1);
  localparam logic [SYM_W-1:0]   SYM_END    = SYM_W'(ALPHABET - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  function automatic logic [NODE_W-1:0] row_entry(logic [ROW_W-1:0] r, logic [SYM_W-1:0] s);
    return r[s*NODE_W +: NODE_W];
  endfunction

  // memories
  logic [ROW_W-1:0]   row_mem   [MAX_NODES];
  logic [NODE_W-1:0]  fail_mem  [MAX_NODES];
  logic [COUNT_W-1:0] end_mem   [MAX_NODES];
  logic [NODE_W-1:0]  queue_mem [MAX_NODES];

  logic [ROW_W-1:0]   row_q;
  logic [NODE_W-1:0]  fail_q;
  logic [COUNT_W-1:0] end_q;
  logic [NODE_W-1:0]  queue_q;

  logic               row_we, row_re, fail_we, fail_re, end_we, end_re, queue_we, queue_re;
  logic [NODE_W-1:0]  row_wa, row_ra, fail_wa, fail_ra, end_wa, end_ra, queue_wa, queue_ra;
  logic [ROW_W-1:0]   row_wd;
  logic [NODE_W-1:0]  fail_wd, queue_wd;
  logic [COUNT_W-1:0] end_wd;

  // item and control registers
  logic [REQ_W-1:0]    req_q;
  logic [LETTER_W-1:0] letter_q;
  logic                last_q;
  logic [NODE_W-1:0]   ins_q, ins_d, scan_q, scan_d, t_q, t_d, clr_q, clr_d, u_q, u_d;
  logic [CNT_W-1:0]    nodes_q, nodes_d, head_q, head_d, tail_q, tail_d;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic                links_q, links_d, ovf_q, ovf_d;
  logic [SYM_W-1:0]    c_q, c_d;
  logic [ROW_W-1:0]    rowu_q, rowu_d;
  logic                out_valid_q, out_valid_d;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  logic [SYM_W-1:0]    sym;
  logic [NODE_W-1:0]   pat_v, ch_v, ch_f, root_v;
  logic [COUNT_W:0]    sum;
  logic                out_free;

  assign sym      = letter_q[SYM_W-1:0];
  assign pat_v    = row_entry(row_q, sym);
  assign root_v   = row_entry(row_q, c_q);
  assign ch_v     = row_entry(rowu_q, c_q);
  assign ch_f     = row_entry(row_q, c_q);
  assign sum      = {1'b0, total_q} + {1'b0, end_q};
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    row_we = 1'b0;   row_wa = clr_q;  row_wd = '0;   row_re = 1'b0;   row_ra = ins_q;
    fail_we = 1'b0;  fail_wa = clr_q; fail_wd = '0;  fail_re = 1'b0;  fail_ra = t_q;
    end_we = 1'b0;   end_wa = clr_q;  end_wd = '0;   end_re = 1'b0;   end_ra = ins_q;
    queue_we = 1'b0; queue_wa = tail_q[NODE_W-1:0];  queue_wd = '0;
    queue_re = 1'b0; queue_ra = head_q[NODE_W-1:0];
    ins_d = ins_q;   scan_d = scan_q; t_d = t_q;     clr_d = clr_q;   u_d = u_q;
    nodes_d = nodes_q; head_d = head_q; tail_d = tail_q; total_d = total_q;
    links_d = links_q; ovf_d = ovf_q; c_d = c_q;     rowu_d = rowu_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_count_d = out_count_q;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_CLR_INIT: begin
        nodes_d = CNT_W'(1); ins_d = '0; scan_d = '0; total_d = '0;
        links_d = 1'b0; ovf_d = 1'b0; clr_d = '0;
      end
      OP_CLR_STEP: begin
        row_we = 1'b1; fail_we = 1'b1; end_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      OP_PAT_FLAG: ovf_d = 1'b1;
      OP_PAT_RD: row_re = 1'b1;
      OP_PAT_UPD: begin
        if (pat_v == '0) begin
          if (nodes_q != NODES_FULL) begin
            row_we = 1'b1;
            row_wa = ins_q;
            row_wd = row_q;
            row_wd[sym*NODE_W +: NODE_W] = nodes_q[NODE_W-1:0];
            ins_d   = nodes_q[NODE_W-1:0];
            nodes_d = nodes_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          ins_d = pat_v;
        end
      end
      OP_END_RD: end_re = 1'b1;
      OP_END_INC: begin
        end_we = 1'b1;
        end_wa = ins_q;
        end_wd = (end_q == COUNT_MAX) ? end_q : end_q + 1'b1;
      end
      OP_PAT_DONE: begin
        out_valid_d = 1'b1;
        out_kind_d  = ovf_q ? KIND_DROPPED : KIND_STORED;
        out_count_d = '0;
        ins_d = '0;
        ovf_d = 1'b0;
      end
      OP_B_ROOT_RD: begin
        row_re = 1'b1; row_ra = '0;
        c_d = '0; head_d = '0; tail_d = '0;
      end
      OP_B_ROOT_C: begin
        if (root_v != '0 && tail_q != NODES_FULL) begin
          queue_we = 1'b1; queue_wd = root_v;
          tail_d   = tail_q + 1'b1;
        end
        c_d = c_q + 1'b1;
      end
      OP_B_Q_RD: begin
        queue_re = 1'b1;
        head_d   = head_q + 1'b1;
      end
      OP_B_U_RD: begin
        u_d = queue_q;
        row_re = 1'b1;  row_ra = queue_q;
        fail_re = 1'b1; fail_ra = queue_q;
      end
      OP_B_F_RD: begin
        rowu_d = row_q;
        row_re = 1'b1; row_ra = fail_q;
        c_d    = '0;
      end
      OP_B_CHILD: begin
        if (ch_v != '0) begin
          fail_we = 1'b1; fail_wa = ch_v; fail_wd = ch_f;
          if (tail_q != NODES_FULL) begin
            queue_we = 1'b1; queue_wd = ch_v;
            tail_d   = tail_q + 1'b1;
          end
        end else begin
          rowu_d[c_q*NODE_W +: NODE_W] = ch_f;
        end
        c_d = c_q + 1'b1;
      end
      OP_B_WB: begin
        row_we = 1'b1; row_wa = u_q; row_wd = rowu_q;
      end
      OP_B_DONE: begin
        links_d = 1'b1;
        ins_d   = '0;
      end
      OP_S_BAD: scan_d = '0;
      OP_S_RD: begin
        row_re = 1'b1; row_ra = scan_q;
      end
      OP_S_STEP: begin
        scan_d = pat_v;
        t_d    = pat_v;
      end
      OP_S_WRD: begin
        end_re = 1'b1; end_ra = t_q;
        fail_re = 1'b1;
      end
      OP_S_WACC: begin
        total_d = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        end_we  = 1'b1; end_wa = t_q;
        t_d     = fail_q;
      end
      OP_S_DONE: begin
        out_valid_d = 1'b1;
        out_kind_d  = KIND_TOTAL;
        out_count_d = total_q;
        total_d = '0;
        scan_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (row_re) row_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    if (fail_re) fail_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (end_we) end_mem[end_wa] <= end_wd;
    if (end_re) end_q <= end_mem[end_ra];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    if (queue_re) queue_q <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q    <= req_type_i;
      letter_q <= letter_i;
      last_q   <= last_i;
    end
    u_q         <= u_d;
    c_q         <= c_d;
    rowu_q      <= rowu_d;
    out_kind_q  <= out_kind_d;
    out_count_q <= out_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q       <= '0;
      scan_q      <= '0;
      t_q         <= '0;
      clr_q       <= '0;
      nodes_q     <= CNT_W'(1);
      head_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      links_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ins_q       <= ins_d;
      scan_q      <= scan_d;
      t_q         <= t_d;
      clr_q       <= clr_d;
      nodes_q     <= nodes_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      links_q     <= links_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.req         = req_q;
  assign status_o.last        = last_q;
  assign status_o.letter_ok   = (int'(letter_q) < ALPHABET);
  assign status_o.links_built = links_q;
  assign status_o.overflow    = ovf_q;
  assign status_o.c_last      = (c_q == SYM_END);
  assign status_o.q_nonempty  = (head_q != tail_q);
  assign status_o.t_zero      = (t_q == '0);
  assign status_o.clr_last    = (clr_q == CLR_END);
  assign status_o.out_free    = out_free;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign match_count_o = out_count_q;

`ifndef SYNTHESIS
  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PAT_DONE || cmd_i.op == OP_S_DONE) |-> out_free)
    else $error("result loaded while previous result still pending");
  a_nodes_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nodes_q != '0) && (nodes_q <= NODES_FULL))
    else $error("node count out of range");
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("build queue head passed tail");
  a_walk_stays_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_S_WRD) |=> (cmd_i.op == OP_S_WACC) && $stable(t_q))
    else $error("fail chain walk lost its node");
`endif

endmodule

// File: sv/aho_corasick_match_counter.sv
`timescale 1ns / 1ps
// aho-corasick match counter: pattern loading, automaton build and text scan
// depends on acm_pkg, acm_if (acm_item_if, acm_result_if), acm_ctrl, acm_datapath
//
// usage
//   item_i carries one letter per transaction: req_type 0 loads a pattern letter,
//   1 scans a text letter, 2 clears every stored pattern. last marks the end of a
//   pattern or a text. result_o returns one transaction per finished pattern
//   (stored or dropped) and one per finished text (saturating match total).
// work per accepted item (results excluded)
//   pattern letter: a trie step, plus an end count update if it ends the pattern
//   text letter: a trie step, then the fail chain walk (one end count and one
//   fail link read per node, then the accumulate)
//   first text letter after loading also builds the automaton: the root row
//   first, then one table row per stored node
//   clear request: one table row swept per cycle
// reset
//   after reset the same row sweep runs with item_i.ready low
// stalls
//   the result sits in an output register; the next item is still accepted and
//   worked on, and the sequencer only waits when it has a new result to post

module aho_corasick_match_counter import acm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  acm_item_if.sink          item_i,
  acm_result_if.source      result_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer: one datapath operation per cycle
  acm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table memories, cursors and result register
  acm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (item_i.req_type),
    .letter_i      (item_i.letter),
    .last_i        (item_i.last),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .result_kind_o (result_o.result_kind),
    .match_count_o (result_o.match_count),
    .status_o      (status)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the aho-corasick match counter
// depends on acm_pkg, acm_if and the aho_corasick_match_counter rtl

module testbench;
  import acm_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } result_t;

  logic clk_i;
  logic rst_ni;

  acm_item_if   item_bus ();
  acm_result_if result_bus ();

  aho_corasick_match_counter u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus.sink),
    .result_o (result_bus.source)
  );

  // clock, 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: trie table, fail links and end counts
  logic [NODE_W-1:0]  trie_next [MAX_NODES*ALPHABET];
  logic [NODE_W-1:0]  trie_fail [MAX_NODES];
  logic [COUNT_W-1:0] trie_ends [MAX_NODES];
  int unsigned        bfs_order [MAX_NODES];
  int unsigned        node_count;
  int unsigned        ins_node;
  int unsigned        scan_node;
  int unsigned        text_total;
  bit                 automaton_built;
  bit                 pattern_dropped;

  result_t expected_results [$];
  int      mismatch_count;
  bit      watchdog_fired;
  int      idle_cycles;
  bit      hold_result_ready;
  int      next_gap;

  function automatic void clear_trie();
    for (int i = 0; i < MAX_NODES*ALPHABET; i++) trie_next[i] = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      trie_fail[i] = '0;
      trie_ends[i] = '0;
    end
    node_count      = 1;
    ins_node        = 0;
    scan_node       = 0;
    text_total      = 0;
    automaton_built = 1'b0;
    pattern_dropped = 1'b0;
  endfunction

  // breadth-first fail link build, missing transitions filled from the fail node
  function automatic void build_automaton();
    int unsigned head, tail, u, f, v;
    head = 0;
    tail = 0;
    for (int c = 0; c < ALPHABET; c++) begin
      v = trie_next[c];
      if (v != 0 && tail < MAX_NODES) begin
        trie_fail[v] = '0;
        bfs_order[tail++] = v;
      end
    end
    while (head < tail) begin
      u = bfs_order[head++];
      f = trie_fail[u];
      for (int c = 0; c < ALPHABET; c++) begin
        v = trie_next[u*ALPHABET + c];
        if (v != 0) begin
          trie_fail[v] = trie_next[f*ALPHABET + c];
          if (tail < MAX_NODES) bfs_order[tail++] = v;
        end else begin
          trie_next[u*ALPHABET + c] = trie_next[f*ALPHABET + c];
        end
      end
    end
    automaton_built = 1'b1;
    ins_node        = 0;
  endfunction

  // expected outcome of one accepted item
  function automatic void predict_item(logic [REQ_W-1:0] req, logic [LETTER_W-1:0] letter,
                                       logic last);
    int unsigned v, t, steps;
    result_t r;
    if (req == REQ_CLEAR) begin
      clear_trie();
    end else if (req == REQ_PATTERN) begin
      if (automaton_built || letter >= ALPHABET) begin
        pattern_dropped = 1'b1;
      end else if (!pattern_dropped) begin
        v = trie_next[ins_node*ALPHABET + letter];
        if (v == 0) begin
          if (node_count < MAX_NODES) begin
            v = node_count++;
            trie_next[ins_node*ALPHABET + letter] = v[NODE_W-1:0];
          end else begin
            pattern_dropped = 1'b1;
          end
        end
        if (!pattern_dropped) ins_node = v;
      end
      if (last) begin
        if (pattern_dropped) begin
          r.kind = KIND_DROPPED;
        end else begin
          if (trie_ends[ins_node] != 16'hffff) trie_ends[ins_node]++;
          r.kind = KIND_STORED;
        end
        r.count = '0;
        expected_results.push_back(r);
        ins_node        = 0;
        pattern_dropped = 1'b0;
      end
    end else if (req == REQ_TEXT) begin
      if (!automaton_built) build_automaton();
      if (letter >= ALPHABET) begin
        scan_node = 0;
      end else begin
        scan_node = trie_next[scan_node*ALPHABET + letter];
        t = scan_node;
        steps = 0;
        // whole fail chain, each end count consumed once
        while (t != 0 && steps < MAX_NODES) begin
          text_total += trie_ends[t];
          if (text_total > 65535) text_total = 65535;
          trie_ends[t] = '0;
          t = trie_fail[t];
          steps++;
        end
      end
      if (last) begin
        r.kind  = KIND_TOTAL;
        r.count = text_total[COUNT_W-1:0];
        expected_results.push_back(r);
        text_total = 0;
        scan_node  = 0;
      end
    end
  endfunction

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one item and wait for its transaction; valid drops before any gap
  task automatic send_item(logic [REQ_W-1:0] req, logic [LETTER_W-1:0] letter, logic last);
    repeat (next_gap) @(posedge clk_i);
    item_bus.valid    <= 1'b1;
    item_bus.req_type <= req;
    item_bus.letter   <= letter;
    item_bus.last     <= last;
    do @(posedge clk_i); while (!(item_bus.ready === 1'b1));
    predict_item(req, letter, last);
    next_gap = gap_length();
    if (next_gap != 0) item_bus.valid <= 1'b0;
  endtask

  task automatic send_word(int unsigned len, bit is_text, int unsigned alpha);
    for (int i = 0; i < len; i++)
      send_item(is_text ? REQ_TEXT : REQ_PATTERN, LETTER_W'($urandom_range(0, alpha-1)),
                i == len-1);
  endtask

  task automatic drain_results();
    if (next_gap == 0) item_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // extremes of the letter field and a classic overlapping pattern set
    send_item(REQ_PATTERN, 5'd0, 1'b1);
    send_item(REQ_PATTERN, 5'd25, 1'b0);
    send_item(REQ_PATTERN, 5'd0, 1'b1);
    send_item(REQ_PATTERN, 5'd1, 1'b0);
    send_item(REQ_PATTERN, 5'd0, 1'b1);
    send_item(REQ_PATTERN, 5'd31, 1'b1);   // bad pattern letter
    send_item(REQ_PATTERN, 5'd3, 1'b0);    // unfinished at build
    send_item(2'd3, 5'd7, 1'b1);           // unused request type
    send_item(REQ_TEXT, 5'd25, 1'b0);      // builds the automaton
    send_item(REQ_TEXT, 5'd0, 1'b0);
    send_item(REQ_TEXT, 5'd26, 1'b0);      // bad text letter
    send_item(REQ_TEXT, 5'd1, 1'b0);
    send_item(REQ_TEXT, 5'd0, 1'b1);
    send_item(REQ_PATTERN, 5'd4, 1'b1);    // late pattern
    send_item(REQ_TEXT, 5'd0, 1'b1);       // counts already consumed
    send_item(REQ_TEXT, 5'd30, 1'b1);
    send_item(REQ_CLEAR, 5'd0, 1'b0);
    send_item(REQ_TEXT, 5'd2, 1'b1);       // empty automaton
    drain_results();
  endtask

  // repeated pattern pushes its end count up, chain walk sums suffixes
  task automatic test_repeat_counts();
    send_item(REQ_CLEAR, 5'd0, 1'b0);
    for (int p = 0; p < 20; p++) begin
      send_item(REQ_PATTERN, 5'd1, 1'b0);
      send_item(REQ_PATTERN, 5'd1, 1'b1);
    end
    send_item(REQ_PATTERN, 5'd1, 1'b1);
    send_word(4, 1'b1, 2);
    drain_results();
  endtask

  task automatic test_random();
    int unsigned n, k, len;
    n = 0;
    while (n < 620) begin
      send_item(REQ_CLEAR, LETTER_W'($urandom), 1'($urandom));
      n++;
      k = $urandom_range(1, 8);
      for (int p = 0; p < k; p++) begin
        len = $urandom_range(1, 4);
        send_word(len, 1'b0, $urandom_range(0, 3) == 0 ? 26 : 3);
        n += len;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(REQ_PATTERN, LETTER_W'($urandom_range(26, 31)), 1'($urandom));
        send_item(2'd3, LETTER_W'($urandom), 1'($urandom));
        n += 2;
      end
      for (int t = 0; t < $urandom_range(1, 4); t++) begin
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(REQ_TEXT, LETTER_W'($urandom_range(26, 31)), i == k-1);
          else send_item(REQ_TEXT, LETTER_W'($urandom_range(0, 2)), i == k-1);
        end
        n += k;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_word(2, 1'b0, 3);   // late
        n += 2;
      end
      // sender hold-off until the block has caught up
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result kind %0d count %0d",
                   result_bus.result_kind, result_bus.match_count);
      end else begin
        exp_r = expected_results.pop_front();
        if (result_bus.result_kind !== exp_r.kind || result_bus.match_count !== exp_r.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind %0d count %0d, got kind %0d count %0d",
                     exp_r.kind, exp_r.count, result_bus.result_kind, result_bus.match_count);
        end
      end
    end
  end

  // result ready with random stalls, some stretches stall free
  always @(posedge clk_i) begin
    int p;
    p = $urandom_range(0, 99);
    if (hold_result_ready) result_bus.ready <= 1'b1;
    else if (p < 3) result_bus.ready <= 1'b0;
    else if (p < 60) result_bus.ready <= 1'b1;
    else result_bus.ready <= (p < 80);
    if ($urandom_range(0, 199) == 0) hold_result_ready <= ~hold_result_ready;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_fired) begin
      watchdog_fired <= 1'b1;
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    item_bus.valid    = 1'b0;
    item_bus.req_type = REQ_PATTERN;
    item_bus.letter   = '0;
    item_bus.last     = 1'b0;
    result_bus.ready  = 1'b0;
    hold_result_ready = 1'b0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    watchdog_fired    = 1'b0;
    next_gap          = 0;
    clear_trie();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_repeat_counts();
    test_random();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
